// ===== src/assert_macros.svh =====
// assertion macros used by the top rtl file of the page table walker
// no dependencies; empty bodies when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("same-cycle assertion failed");

`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("next-cycle assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs)

`define ASSERT_NEXT(label, clk, rst, lhs, rhs)

`endif

`endif

// ===== src/ptw_pkg.sv =====
// shared types, codes and constants of the four-level page table walker
// no dependencies
package ptw_pkg;

   localparam int PAGE_OFFSET_BITS = 12;
   localparam int INDEX_BITS       = 9;
   localparam int VA_W             = 48;
   localparam int PA_W             = 52;
   localparam int ENTRY_W          = 64;
   localparam int LARGE_PAGE_BIT   = 7;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int REQ_DATA_W = VA_W + ENTRY_W;                    // 112, whole bytes
   localparam int RSP_BITS   = PA_W + 2 * ENTRY_W + 1;            // 181
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;          // 184

   localparam logic CMD_TRANSLATE = 1'b0;
   localparam logic CMD_RESPONSE  = 1'b1;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   typedef struct packed {
      logic                  is_translate;
      logic [VA_W-1:0]       virtual_address;
      logic [ENTRY_W-1:0]    read_data;
      logic                  table_zero;
      logic                  large_page;
   } ptw_item_type;

endpackage

// ===== src/ptw_queue.sv =====
// short fifo between the front and back parts of the walker
// depends on ptw_pkg
module ptw_queue #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ptw_pkg::ptw_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  q_valid,
   output ptw_pkg::ptw_item_type q_item
);
   import ptw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   ptw_item_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== src/ptw_front.sv =====
// front part: accepts input transactions and classifies them for the queue
// depends on ptw_pkg
module ptw_front (
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [ptw_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   input  logic                           queue_full,
   output logic                           push,
   output ptw_pkg::ptw_item_type          push_item
);
   import ptw_pkg::*;

   logic [ENTRY_W-1:0] entry;

   assign entry      = req_tdata[VA_W +: ENTRY_W];
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   always_comb begin
      push_item.is_translate    = (req_tuser == CMD_TRANSLATE);
      push_item.virtual_address = req_tdata[VA_W-1:0];
      push_item.read_data       = entry;
      // table address is the entry without its page offset bits
      push_item.table_zero      = (entry[ENTRY_W-1:PAGE_OFFSET_BITS] == '0);
      push_item.large_page      = entry[LARGE_PAGE_BIT];
   end

endmodule

// ===== src/ptw_back.sv =====
// back part: walk state machine, root base register and output register
// depends on ptw_pkg
module ptw_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wen,
   input  logic [ptw_pkg::PA_W-1:0]       csr_wdata,
   input  logic                           q_valid,
   input  ptw_pkg::ptw_item_type          q_item,
   output logic                           pop,
   output logic                           walk_busy,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [ptw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser
);
   import ptw_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_L0   = 5'b00010,
      ST_L1   = 5'b00100,
      ST_L2   = 5'b01000,
      ST_L3   = 5'b10000
   } ptw_state_type;

   localparam int SH_L0 = PAGE_OFFSET_BITS + 3 * INDEX_BITS;
   localparam int SH_L1 = PAGE_OFFSET_BITS + 2 * INDEX_BITS;
   localparam int SH_L2 = PAGE_OFFSET_BITS + INDEX_BITS;
   localparam int SH_L3 = PAGE_OFFSET_BITS;
   localparam int PAD_W = RSP_DATA_W - RSP_BITS;

   ptw_state_type       state_ff, state_in;
   logic [VA_W-1:0]     held_ff, held_in;
   logic [PA_W-1:0]     root_ff;
   logic                valid_ff, valid_in;
   logic                kind_ff, kind_in;
   logic [PA_W-1:0]     addr_ff, addr_in;
   logic [ENTRY_W-1:0]  page_ff, page_in;
   logic [ENTRY_W-1:0]  phys_ff, phys_in;
   logic                mapped_ff, mapped_in;

   logic                emit;
   logic [ENTRY_W-1:0]  masked;
   logic [PA_W-1:0]     base;
   logic [INDEX_BITS-1:0] idx;

   assign pop       = q_valid && (!valid_ff || rsp_tready);
   assign masked    = {q_item.read_data[ENTRY_W-1:PAGE_OFFSET_BITS], PAGE_OFFSET_BITS'(0)};
   assign walk_busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in  = state_ff;
      held_in   = held_ff;
      emit      = 1'b0;
      kind_in   = KIND_READ;
      base      = masked[PA_W-1:0];
      idx       = '0;
      page_in   = '0;
      phys_in   = '0;
      mapped_in = 1'b0;
      if (pop) begin
         if (q_item.is_translate) begin
            if (state_ff == ST_IDLE) begin
               held_in  = q_item.virtual_address;
               state_in = ST_L0;
               emit     = 1'b1;
               base     = root_ff;
               idx      = q_item.virtual_address[SH_L0 +: INDEX_BITS];
            end
         end else begin
            unique case (state_ff) inside
               ST_IDLE: begin
                  // stray response, dropped
               end
               ST_L0, ST_L1: begin
                  emit = 1'b1;
                  if (q_item.table_zero) begin
                     kind_in  = KIND_DONE;
                     state_in = ST_IDLE;
                  end else begin
                     state_in = (state_ff == ST_L0) ? ST_L1 : ST_L2;
                     idx      = (state_ff == ST_L0) ? held_ff[SH_L1 +: INDEX_BITS]
                                                    : held_ff[SH_L2 +: INDEX_BITS];
                  end
               end
               ST_L2: begin
                  emit = 1'b1;
                  if (q_item.table_zero) begin
                     kind_in  = KIND_DONE;
                     state_in = ST_IDLE;
                  end else if (q_item.large_page) begin
                     kind_in   = KIND_DONE;
                     state_in  = ST_IDLE;
                     page_in   = masked;
                     phys_in   = masked;
                     mapped_in = 1'b1;
                  end else begin
                     state_in = ST_L3;
                     idx      = held_ff[SH_L3 +: INDEX_BITS];
                  end
               end
               ST_L3: begin
                  emit      = 1'b1;
                  kind_in   = KIND_DONE;
                  state_in  = ST_IDLE;
                  page_in   = q_item.read_data;
                  phys_in   = masked;
                  mapped_in = 1'b1;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
      end
      addr_in  = (kind_in == KIND_READ)
               ? base + PA_W'({idx, 3'b000})
               : '0;
      valid_in = emit || (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         root_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (csr_wen) begin
            root_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      if (emit) begin
         kind_ff   <= kind_in;
         addr_ff   <= addr_in;
         page_ff   <= page_in;
         phys_ff   <= phys_in;
         mapped_ff <= mapped_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {PAD_W'(0), mapped_ff, phys_ff, page_ff, addr_ff};

endmodule

// ===== src/four_level_page_table_walker.sv =====
// four-level page table walker: front classifier, queue, back walk engine
// an accepted transaction is registered in the queue, and its result in the output register behind rsp_tvalid
// throughput: one transaction per cycle from the queue while the output register is empty or rsp_tready is high
// a stalled result holds in the output register while the queue keeps filling
// reset is synchronous, active high: clears queue, walk state, output valid and
// root_table_base
`include "assert_macros.svh"

module four_level_page_table_walker #(
   parameter int QUEUE_DEPTH = ptw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wen,
   input  logic [ptw_pkg::PA_W-1:0]       csr_wdata,    // root_table_base
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [47:0] virtual_address, [111:48] read_data
   input  logic [ptw_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,    // [0] command
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [51:0] read_address, [115:52] page_entry, [179:116] physical_address,
   // [180] mapped, [183:181] zero
   output logic [ptw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser     // [0] result_kind
);
   import ptw_pkg::*;

   logic         queue_full;
   logic         push;
   ptw_item_type push_item;
   logic         q_valid;
   ptw_item_type q_item;
   logic         pop;
   logic         walk_busy;

   ptw_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   ptw_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_item    (q_item)
   );

   ptw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .pop        (pop),
      .walk_busy  (walk_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // an accepted transaction is queued for the back engine
   `ASSERT_NEXT(a_accept_queued, clock, reset, req_tvalid && req_tready, q_valid)
   // the back engine does not drain the queue while its result is stalled
   `ASSERT_NEXT(a_hold_on_stall, clock, reset,
      q_valid && rsp_tvalid && !rsp_tready, q_valid)
   // a pending read request always belongs to a walk in progress
   `ASSERT_IMPLIES(a_read_while_busy, clock, reset,
      rsp_tvalid && (rsp_tuser == KIND_READ), walk_busy)

endmodule

// ===== bench/four_level_page_table_walker_checker.sv =====
// checker for the four-level page table walker: watches the request, result and csr ports,
// predicts each walk step and compares results field by field; depends on ptw_pkg
`timescale 1ns / 1ps

module four_level_page_table_walker_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wen,
   input  logic [ptw_pkg::PA_W-1:0]       csr_wdata,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [ptw_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [ptw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tuser,
   output int                             mismatch_count,
   output int                             outstanding
);
   import ptw_pkg::*;

   typedef struct packed {
      logic               kind;
      logic [PA_W-1:0]    read_address;
      logic [ENTRY_W-1:0] page_entry;
      logic [ENTRY_W-1:0] physical_address;
      logic               mapped;
   } walk_result_type;

   walk_result_type    walk_results_q[$];
   logic [PA_W-1:0]    root_base;
   logic               walking;
   logic [1:0]         depth;
   logic [VA_W-1:0]    held_va;

   task automatic flag_result(input string why, input walk_result_type want,
                              input walk_result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected kind %0d addr %h entry %h phys %h mapped %0d", why,
                  want.kind, want.read_address, want.page_entry, want.physical_address,
                  want.mapped);
         $display("   actual kind %0d addr %h entry %h phys %h mapped %0d",
                  got.kind, got.read_address, got.page_entry, got.physical_address,
                  got.mapped);
      end
   endtask

   always @(posedge clock) begin
      walk_result_type    got;
      walk_result_type    want;
      walk_result_type    step;
      logic [ENTRY_W-1:0] entry;
      logic [ENTRY_W-1:0] tbl;
      logic               emit;
      if (reset) begin
         walk_results_q.delete();
         root_base      = '0;
         walking        = 1'b0;
         depth          = '0;
         held_va        = '0;
         mismatch_count = 0;
      end else begin
         if (csr_wen)
            root_base = csr_wdata;

         // results first so that a transaction on the same edge cannot match itself
         if (rsp_tvalid && rsp_tready) begin
            got.kind             = rsp_tuser;
            got.read_address     = rsp_tdata[51:0];
            got.page_entry       = rsp_tdata[115:52];
            got.physical_address = rsp_tdata[179:116];
            got.mapped           = rsp_tdata[180];
            if (walk_results_q.size() == 0) begin
               flag_result("unexpected result", '0, got);
            end else begin
               want = walk_results_q.pop_front();
               if (got !== want)
                  flag_result("result mismatch", want, got);
            end
         end

         if (req_tvalid && req_tready) begin
            emit  = 1'b0;
            step  = '0;
            entry = req_tdata[111:48];
            tbl   = {entry[ENTRY_W-1:PAGE_OFFSET_BITS], {PAGE_OFFSET_BITS{1'b0}}};
            if (req_tuser == CMD_TRANSLATE) begin
               if (!walking) begin
                  held_va           = req_tdata[VA_W-1:0];
                  depth             = '0;
                  walking           = 1'b1;
                  emit              = 1'b1;
                  step.kind         = KIND_READ;
                  step.read_address = root_base + {held_va[VA_W-1 -: INDEX_BITS], 3'b000};
               end
            end else if (walking) begin
               emit = 1'b1;
               if (depth == 2'd3 || tbl == '0 || (depth == 2'd2 && entry[LARGE_PAGE_BIT])) begin
                  step.kind   = KIND_DONE;
                  step.mapped = (depth == 2'd3 || tbl != '0);
                  if (depth == 2'd3)
                     step.page_entry = entry;
                  else if (tbl != '0)
                     step.page_entry = tbl;   // large page: no offset added
                  step.physical_address = step.mapped ? tbl : '0;
                  walking = 1'b0;
                  depth   = '0;
               end else begin
                  depth             = depth + 2'd1;
                  step.kind         = KIND_READ;
                  step.read_address = tbl[PA_W-1:0] +
                     {held_va[VA_W-1 - INDEX_BITS*depth -: INDEX_BITS], 3'b000};
               end
            end
            if (emit)
               walk_results_q.push_back(step);
         end
      end
      outstanding <= walk_results_q.size();
   end

endmodule

// ===== bench/four_level_page_table_walker_tb.sv =====
// testbench top for the four-level page table walker: clock, reset, walk stimulus and verdict
// depends on ptw_pkg, the walker rtl and four_level_page_table_walker_checker
`timescale 1ns / 1ps

module four_level_page_table_walker_tb;
   import ptw_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   logic                  clock;
   logic                  reset;
   logic                  csr_wen;
   logic [PA_W-1:0]       csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [47:0] virtual_address, [111:48] read_data
   logic                  req_tuser;   // [0] command
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [51:0] read_address, [115:52] page_entry,
                                       // [179:116] physical_address, [180] mapped
   logic                  rsp_tuser;   // [0] result_kind

   int       failures;
   int       pending_results;
   int       idle_cycles;
   bit       quiet;
   int       gap_pct;
   bit       walk_open;
   logic [1:0] walk_depth;
   int       walk_items;

   four_level_page_table_walker u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   four_level_page_table_walker_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (failures),
      .outstanding    (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // table entry for the given level: mostly a fresh table, sometimes a zero table
   // address, and at level two often a large page
   function automatic logic [ENTRY_W-1:0] pick_entry(input logic [1:0] lvl);
      logic [ENTRY_W-1:0] e;
      int                 r;
      r = $urandom_range(0, 99);
      e = {$urandom, $urandom};
      if (r < 12)
         e[ENTRY_W-1:PAGE_OFFSET_BITS] = '0;
      else if (lvl == 2'd2)
         e[LARGE_PAGE_BIT] = (r < 45);
      if (lvl == 2'd3 && r < 5)
         e = '0;
      return e;
   endfunction

   task automatic send_item(input logic cmd, input logic [VA_W-1:0] va,
                            input logic [ENTRY_W-1:0] data);
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {data, va};
      do @(posedge clock); while (!req_tready);
      // track where the walk stands so that the next transaction is well formed
      if (cmd == CMD_TRANSLATE) begin
         if (!walk_open) begin
            walk_open  = 1'b1;
            walk_depth = '0;
            walk_items++;
         end
      end else if (walk_open) begin
         walk_items++;
         if (walk_depth == 2'd3 || data[ENTRY_W-1:PAGE_OFFSET_BITS] == '0 ||
             (walk_depth == 2'd2 && data[LARGE_PAGE_BIT]))
            walk_open = 1'b0;
         else
            walk_depth = walk_depth + 2'd1;
      end
   endtask

   task automatic write_root(input logic [PA_W-1:0] base);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (8) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= base;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (quiet) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 12))
               @(posedge clock);
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
      end
   end

   // ends the run when nothing moves for too long
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wen || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("four_level_page_table_walker regression: fail");
      $finish;
   end

   initial begin
      logic [PA_W-1:0] base;
      int              phase;
      quiet      = 1'b0;
      gap_pct    = 20;
      walk_open  = 1'b0;
      walk_depth = '0;
      walk_items = 0;
      reset      <= 1'b1;
      csr_wen    <= 1'b0;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= CMD_TRANSLATE;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // zero root, unmapped at the top level
      write_root('0);
      send_item(CMD_TRANSLATE, '0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(CMD_RESPONSE, 48'hFFFF_FFFF_FFFF, '0);
      // all-ones address, truncated next-level address, large page at level two
      send_item(CMD_TRANSLATE, 48'hFFFF_FFFF_FFFF, '0);
      send_item(CMD_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(CMD_RESPONSE, '0, 64'h0000_0000_0012_3080);
      send_item(CMD_RESPONSE, '0, 64'h0000_0000_4560_0080);
      // stray response while idle
      send_item(CMD_RESPONSE, '0, 64'h0000_0000_0000_7000);
      // translate while busy, then zero table address with low bits set
      send_item(CMD_TRANSLATE, 48'h1234_5678_9ABC, '0);
      send_item(CMD_TRANSLATE, 48'h0FED_CBA9_8765, '0);
      send_item(CMD_RESPONSE, '0, 64'h0000_0000_0000_1000);
      send_item(CMD_RESPONSE, '0, 64'h0000_0000_0000_0FFF);
      // full walk ending in a zero level-three entry
      send_item(CMD_TRANSLATE, 48'h8000_0000_0000, '0);
      send_item(CMD_RESPONSE, '0, 64'h8000_0000_0000_0000);
      send_item(CMD_RESPONSE, '0, 64'h0000_0000_0000_2007);
      send_item(CMD_RESPONSE, '0, 64'h0000_0000_0000_3000);
      send_item(CMD_RESPONSE, '0, '0);
      // zero table at level two with the large page bit set: still unmapped
      send_item(CMD_TRANSLATE, 48'h0000_4020_1000, '0);
      send_item(CMD_RESPONSE, '0, 64'h0000_0000_0000_5000);
      send_item(CMD_RESPONSE, '0, 64'h0000_0000_0000_6000);
      send_item(CMD_RESPONSE, '0, 64'h0000_0000_0000_0080);
      // all-ones root wraps on the first request
      write_root({PA_W{1'b1}});
      send_item(CMD_TRANSLATE, 48'hFFFF_FFFF_FFFF, '0);
      send_item(CMD_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FF7F);
      send_item(CMD_RESPONSE, '0, 64'h0000_0000_0000_1000);
      send_item(CMD_RESPONSE, '0, 64'h0000_0000_0000_2000);
      send_item(CMD_RESPONSE, '0, 64'hFFFF_FFFF_FFFF_FFFF);

      for (phase = 0; phase < 6; phase++) begin
         base = PA_W'({$urandom, $urandom});
         if ($urandom_range(0, 1) == 1)
            base[PAGE_OFFSET_BITS-1:0] = '0;
         write_root(base);
         gap_pct    = (phase == 1) ? 0 : 30;
         quiet      = (phase == 5);
         walk_items = 0;
         while (walk_items < 100) begin
            if ($urandom_range(0, 99) < 8)
               send_item(CMD_RESPONSE, VA_W'({$urandom, $urandom}), {$urandom, $urandom});
            send_item(CMD_TRANSLATE, VA_W'({$urandom, $urandom}), {$urandom, $urandom});
            while (walk_open) begin
               if ($urandom_range(0, 99) < 8)
                  send_item(CMD_TRANSLATE, VA_W'({$urandom, $urandom}), {$urandom, $urandom});
               send_item(CMD_RESPONSE, VA_W'({$urandom, $urandom}), pick_entry(walk_depth));
            end
         end
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (10) @(posedge clock);
      if (failures == 0)
         $display("four_level_page_table_walker regression: pass");
      else
         $display("four_level_page_table_walker regression: fail");
      $finish;
   end

endmodule
